FILE: rtl/sphere_contact_spring_force_core_defines.svh
// assertion macros for the sphere contact spring force core
// no dependencies; taken in by the top level
`ifndef SPHERE_CONTACT_SPRING_FORCE_CORE_DEFINES_SVH
`define SPHERE_CONTACT_SPRING_FORCE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked while out of reset
`define SCSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scsf assertion failed");
// next-cycle implication, checked while out of reset
`define SCSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scsf assertion failed");
`else
`define SCSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SCSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/scsf_pkg.sv
// package for the sphere contact spring force core
// default widths and the reset stiffness; no dependencies
`timescale 1ns / 1ps
package scsf_pkg;
    localparam int SCSF_FRAC_BITS  = 16;
    localparam int SCSF_WORD_BITS  = 32;
    // reset stiffness in whole units, shifted by the fraction width at use
    localparam int SCSF_K_RESET_INT = 1000;
endpackage

FILE: rtl/sphere_contact_spring_force_core.sv
// sphere contact spring force core: linear-spring normal force of one sphere pair
// depends on scsf_pkg and sphere_contact_spring_force_core_defines.svh
`timescale 1ns / 1ps
// usage
// - input channel: i_in_valid / o_in_stall carry one candidate pair a beat
//   (two centres, two radii); a beat is taken when valid is high and stall low
// - output channel: o_out_valid / i_out_stall carry the force on sphere b plus
//   the contact, coincident and saturated flags, one result beat per pair
// - config channel: i_cfg_valid / o_cfg_ready write the stiffness; ready is
//   always high, write only while the pipe is empty
// - pipeline: a bit-per-stage square root of WORD_BITS+2 stages and a
//   bit-per-stage restoring divider of WORD_BITS stages
// - throughput: one pair per cycle while the output is not stalled, every
//   stage is its own register with a valid bit
// - stall: each stage holds only while it is full and the stage after it
//   holds, so bubbles close up and the input keeps taking beats until the
//   whole pipe is full behind a stalled result
// - reset: synchronous active low; clears all valid bits and loads the
//   stiffness with 1000.0
module sphere_contact_spring_force_core #(
    parameter int FRAC_BITS = scsf_pkg::SCSF_FRAC_BITS,
    parameter int WORD_BITS = scsf_pkg::SCSF_WORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [WORD_BITS-1:0]        i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [WORD_BITS-1:0] i_pos_a_x,
    input  logic signed [WORD_BITS-1:0] i_pos_a_y,
    input  logic signed [WORD_BITS-1:0] i_pos_a_z,
    input  logic signed [WORD_BITS-1:0] i_pos_b_x,
    input  logic signed [WORD_BITS-1:0] i_pos_b_y,
    input  logic signed [WORD_BITS-1:0] i_pos_b_z,
    input  logic [WORD_BITS-2:0]        i_radius_a,
    input  logic [WORD_BITS-2:0]        i_radius_b,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [WORD_BITS-1:0] o_force_x,
    output logic signed [WORD_BITS-1:0] o_force_y,
    output logic signed [WORD_BITS-1:0] o_force_z,
    output logic                        o_in_contact,
    output logic                        o_coincident,
    output logic                        o_saturated
);
    import scsf_pkg::*;
`include "sphere_contact_spring_force_core_defines.svh"

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int MW  = W + 1;            // magnitude of a coordinate difference
    localparam int SW  = 2 * MW + 2;       // sum of three squares
    localparam int RW  = MW + 1;           // root of that sum
    localparam int NW  = 3 * W + 1;        // stiffness * overlap * magnitude
    localparam int DW  = 2 * W + 2 + F;    // divisor shifted to the top quotient bit
    localparam int LW  = (NW > DW) ? NW : DW;
    localparam int PW  = W + MW;           // one partial product

    // stage map
    localparam int SQ0  = 3;               // first root stage
    localparam int CT   = SQ0 + RW;        // contact test, overlap
    localparam int KS   = CT + 1;          // stiffness * overlap
    localparam int PS   = KS + 1;          // partial products
    localparam int NS   = PS + 1;          // numerator sum
    localparam int BS   = NS + 1;          // quotient range check
    localparam int DV0  = BS + 1;          // first divider stage
    localparam int FS   = DV0 + W;         // clip, sign, masking
    localparam int NSTG = FS + 1;

    typedef struct packed {
        logic [2:0][MW-1:0] mag;
        logic [2:0]         neg;
        logic [W-1:0]       rsum;
        logic               zero;
        logic [SW-1:0]      rem;
        logic [RW-1:0]      root;
        logic               contact;
        logic [W-1:0]       ovl;
        logic [2*W-1:0]     kd;
        logic [2:0][LW-1:0] num;
        logic [2:0][PW-1:0] ph;
        logic [2:0]         big;
        logic [2:0][W-1:0]  q;
        logic               sat;
    } t_item;

    logic [W-1:0]      r_stiffness;
    t_item             r_stg [NSTG];
    logic [NSTG-1:0]   r_v;
    logic [NSTG-1:0]   w_en;
    logic [2:0][W-1:0] w_pa;
    logic [2:0][W-1:0] w_pb;

    assign w_pa = {i_pos_a_z, i_pos_a_y, i_pos_a_x};
    assign w_pb = {i_pos_b_z, i_pos_b_y, i_pos_b_x};

    // stiffness register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiffness <= W'(64'(SCSF_K_RESET_INT) << F);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_stiffness <= i_cfg_data;
        end
    end

    // a stage loads when empty or when the stage after it moves on
    assign w_en[NSTG-1] = !r_v[NSTG-1] || !i_out_stall;
    for (genvar gk = 0; gk < NSTG - 1; gk++) begin : g_en
        assign w_en[gk] = !r_v[gk] || w_en[gk+1];
    end
    assign o_in_stall = !w_en[0];

    for (genvar gk = 0; gk < NSTG; gk++) begin : g_stg
        t_item n_s;

        if (gk == 0) begin : g_diff
            // coordinate differences as sign and magnitude, radius sum
            logic [W:0] d;
            always_comb begin
                n_s = '0;
                d   = '0;
                for (int k = 0; k < 3; k++) begin
                    d = {w_pb[k][W-1], w_pb[k]} - {w_pa[k][W-1], w_pa[k]};
                    n_s.neg[k] = d[W];
                    n_s.mag[k] = d[W] ? (~d + 1'b1) : d;
                end
                n_s.rsum = {1'b0, i_radius_a} + {1'b0, i_radius_b};
                n_s.zero = (n_s.mag == '0);
            end
        end else if (gk == 1) begin : g_sq
            logic [2*MW-1:0] p;
            always_comb begin
                n_s = r_stg[gk-1];
                p   = '0;
                for (int k = 0; k < 3; k++) begin
                    p = r_stg[gk-1].mag[k] * r_stg[gk-1].mag[k];
                    n_s.num[k] = LW'(p);
                end
            end
        end else if (gk == 2) begin : g_sum
            always_comb begin
                n_s      = r_stg[gk-1];
                n_s.rem  = SW'(r_stg[gk-1].num[0]) + SW'(r_stg[gk-1].num[1])
                         + SW'(r_stg[gk-1].num[2]);
                n_s.root = '0;
            end
        end else if (gk < CT) begin : g_root
            // one root bit: keep it if (root + 2^b)^2 still fits under the sum
            localparam int B = RW - 1 - (gk - SQ0);
            logic [SW:0] t;
            always_comb begin
                n_s = r_stg[gk-1];
                t   = ((SW+1)'(r_stg[gk-1].root) << (B + 1)) | ((SW+1)'(1) << (2 * B));
                if ({1'b0, r_stg[gk-1].rem} >= t) begin
                    n_s.rem  = r_stg[gk-1].rem - t[SW-1:0];
                    n_s.root = r_stg[gk-1].root | (RW'(1) << B);
                end
            end
        end else if (gk == CT) begin : g_ct
            always_comb begin
                n_s         = r_stg[gk-1];
                n_s.contact = {2'b0, r_stg[gk-1].rsum} > r_stg[gk-1].root;
                n_s.ovl     = r_stg[gk-1].rsum - r_stg[gk-1].root[W-1:0];
            end
        end else if (gk == KS) begin : g_kd
            always_comb begin
                n_s    = r_stg[gk-1];
                n_s.kd = r_stiffness * r_stg[gk-1].ovl;
            end
        end else if (gk == PS) begin : g_pp
            // split the wide product into two halves of the stiffness term
            logic [PW-1:0] lo;
            always_comb begin
                n_s = r_stg[gk-1];
                lo  = '0;
                for (int k = 0; k < 3; k++) begin
                    lo         = r_stg[gk-1].kd[W-1:0] * r_stg[gk-1].mag[k];
                    n_s.num[k] = LW'(lo);
                    n_s.ph[k]  = r_stg[gk-1].kd[2*W-1:W] * r_stg[gk-1].mag[k];
                end
            end
        end else if (gk == NS) begin : g_num
            always_comb begin
                n_s = r_stg[gk-1];
                for (int k = 0; k < 3; k++) begin
                    n_s.num[k] = r_stg[gk-1].num[k] + (LW'(r_stg[gk-1].ph[k]) << W);
                end
            end
        end else if (gk == BS) begin : g_big
            // quotient of 2^W or more always clips
            always_comb begin
                n_s   = r_stg[gk-1];
                n_s.q = '0;
                for (int k = 0; k < 3; k++) begin
                    n_s.big[k] = r_stg[gk-1].num[k] >= (LW'(r_stg[gk-1].root) << (F + W));
                end
            end
        end else if (gk < FS) begin : g_div
            localparam int B = W - 1 - (gk - DV0);
            logic [LW-1:0] t;
            always_comb begin
                n_s = r_stg[gk-1];
                t   = LW'(r_stg[gk-1].root) << (F + B);
                for (int k = 0; k < 3; k++) begin
                    if (r_stg[gk-1].num[k] >= t) begin
                        n_s.num[k]  = r_stg[gk-1].num[k] - t;
                        n_s.q[k][B] = 1'b1;
                    end
                end
            end
        end else begin : g_fin
            // clip to the signed range, apply sign, zero when no contact or coincident
            logic [W-1:0] lim;
            logic [W-1:0] mq;
            logic         over;
            always_comb begin
                n_s     = r_stg[gk-1];
                n_s.sat = 1'b0;
                lim     = '0;
                mq      = '0;
                over    = 1'b0;
                for (int k = 0; k < 3; k++) begin
                    lim  = r_stg[gk-1].neg[k] ? (W'(1) << (W - 1))
                                              : ((W'(1) << (W - 1)) - 1'b1);
                    over = r_stg[gk-1].big[k] || (r_stg[gk-1].q[k] > lim);
                    mq   = over ? lim : r_stg[gk-1].q[k];
                    if (!r_stg[gk-1].contact || r_stg[gk-1].zero) begin
                        n_s.q[k] = '0;
                    end else begin
                        n_s.q[k] = r_stg[gk-1].neg[k] ? (~mq + 1'b1) : mq;
                        n_s.sat  = n_s.sat | over;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gk] <= 1'b0;
            end else if (w_en[gk]) begin
                r_v[gk] <= (gk == 0) ? i_in_valid : r_v[(gk == 0) ? 0 : gk - 1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[gk]) begin
                r_stg[gk] <= n_s;
            end
        end
    end

    assign o_out_valid  = r_v[FS];
    assign o_force_x    = r_stg[FS].q[0];
    assign o_force_y    = r_stg[FS].q[1];
    assign o_force_z    = r_stg[FS].q[2];
    assign o_in_contact = r_stg[FS].contact;
    assign o_coincident = r_stg[FS].zero;
    assign o_saturated  = r_stg[FS].sat;

    // coincident centres never produce force
    `SCSF_ASSERT_NOW(a_coinc_zero, i_clk, i_rst_n, o_out_valid && o_coincident,
        o_force_x == '0 && o_force_y == '0 && o_force_z == '0 && !o_saturated)
    // no contact, no force
    `SCSF_ASSERT_NOW(a_nocontact_zero, i_clk, i_rst_n, o_out_valid && !o_in_contact,
        o_force_x == '0 && o_force_y == '0 && o_force_z == '0 && !o_saturated)
    // a clip only happens on a real contact
    `SCSF_ASSERT_NOW(a_sat_contact, i_clk, i_rst_n, o_out_valid && o_saturated,
        o_in_contact && !o_coincident)
    // a held result beat keeps its x force and saturated flag
    `SCSF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_force_x) && $stable(o_saturated))
endmodule

FILE: tb/sv/testbench.sv
// testbench for the sphere contact spring force core: directed and random pairs
// depends on scsf_pkg and the core; checks each result beat against a local predictor
`timescale 1ns / 1ps
module testbench;
    import scsf_pkg::*;

    localparam int FB = SCSF_FRAC_BITS;
    localparam int WB = SCSF_WORD_BITS;
    localparam int LATENCY = 2 * WB + 11;

    typedef struct packed {
        logic signed [WB-1:0] ax, ay, az, bx, by, bz;
        logic [WB-2:0]        ra, rb;
    } t_pair;

    typedef struct packed {
        logic signed [WB-1:0] fx, fy, fz;
        logic                 contact, coinc, sat;
    } t_force;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [WB-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_pair pair_drv = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [WB-1:0] o_force_x, o_force_y, o_force_z;
    logic o_in_contact, o_coincident, o_saturated;

    t_force expected_forces[$];
    logic [WB-1:0] stiffness_q = WB'(SCSF_K_RESET_INT) << FB;
    int errors = 0;
    int idle_pct = 25;      // chance of a gap on either side
    int hold_request = 0;   // bumped by a test to start a receiver hold-off
    int hold_taken = 0;     // last hold-off request seen by the receiver
    int hold_cycles = 0;    // cycles left in the current hold-off

    always #10 i_clk = ~i_clk;

    sphere_contact_spring_force_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_pos_a_x(pair_drv.ax), .i_pos_a_y(pair_drv.ay), .i_pos_a_z(pair_drv.az),
        .i_pos_b_x(pair_drv.bx), .i_pos_b_y(pair_drv.by), .i_pos_b_z(pair_drv.bz),
        .i_radius_a(pair_drv.ra), .i_radius_b(pair_drv.rb),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_force_x(o_force_x), .o_force_y(o_force_y), .o_force_z(o_force_z),
        .o_in_contact(o_in_contact), .o_coincident(o_coincident),
        .o_saturated(o_saturated)
    );

    // predicted force on sphere b, exact wide arithmetic
    function automatic t_force spring_force(t_pair p, logic [WB-1:0] kn);
        t_force r;
        logic signed [WB:0] d[3];
        logic [WB:0] mag[3];
        logic [2*WB+3:0] sumsq;
        logic [WB+1:0] root, cand;
        logic [WB:0] rsum;
        logic [3*WB+8:0] num, den, q;
        logic [3*WB+8:0] lim;
        r = '0;
        d[0] = $signed({p.bx[WB-1], p.bx}) - $signed({p.ax[WB-1], p.ax});
        d[1] = $signed({p.by[WB-1], p.by}) - $signed({p.ay[WB-1], p.ay});
        d[2] = $signed({p.bz[WB-1], p.bz}) - $signed({p.az[WB-1], p.az});
        sumsq = '0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = d[k][WB] ? -d[k] : d[k];
            sumsq += mag[k] * mag[k];
        end
        rsum = p.ra + p.rb;
        if (sumsq == 0) begin
            r.contact = (rsum != 0);
            r.coinc = 1'b1;
            return r;
        end
        root = '0;
        for (int b = WB + 1; b >= 0; b--) begin
            cand = root | ((WB+2)'(1) << b);
            if ((2*WB+4)'(cand) * (2*WB+4)'(cand) <= sumsq) root = cand;
        end
        if (rsum <= root) return r;
        r.contact = 1'b1;
        den = (3*WB+9)'(root) << FB;
        for (int k = 0; k < 3; k++) begin
            num = (3*WB+9)'(kn) * (3*WB+9)'(rsum - root) * (3*WB+9)'(mag[k]);
            q = num / den;
            lim = d[k][WB] ? ((3*WB+9)'(1) << (WB-1)) : (((3*WB+9)'(1) << (WB-1)) - 1);
            if (q > lim) begin
                q = lim;
                r.sat = 1'b1;
            end
            case (k)
                0: r.fx = d[k][WB] ? -WB'(q) : WB'(q);
                1: r.fy = d[k][WB] ? -WB'(q) : WB'(q);
                default: r.fz = d[k][WB] ? -WB'(q) : WB'(q);
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [WB-1:0] got, logic [WB-1:0] want);
        $display("error: %s got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // send one pair beat, with random leading gaps; valid stays up for a following beat
    task automatic send_pair(t_pair p);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        expected_forces.push_back(spring_force(p, stiffness_q));
        pair_drv <= p;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (expected_forces.size() != 0) begin
            @(negedge i_clk);
            guard++;
            if (guard > 200000) begin
                $display("sphere_contact_spring_force_core: mismatch");
                $finish;
            end
        end
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    task automatic write_stiffness(logic [WB-1:0] kn);
        drain();
        i_cfg_data <= kn;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        stiffness_q = kn;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver: random stall, plus a counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_request != hold_taken) begin
            hold_taken <= hold_request;
            hold_cycles <= 3 * LATENCY;
            i_out_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_force w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_forces.size() == 0) begin
                report_mismatch("unexpected beat", '0, '0);
            end else begin
                w = expected_forces.pop_front();
                if (o_force_x !== w.fx) report_mismatch("force_x", o_force_x, w.fx);
                if (o_force_y !== w.fy) report_mismatch("force_y", o_force_y, w.fy);
                if (o_force_z !== w.fz) report_mismatch("force_z", o_force_z, w.fz);
                if (o_in_contact !== w.contact)
                    report_mismatch("in_contact", o_in_contact, w.contact);
                if (o_coincident !== w.coinc)
                    report_mismatch("coincident", o_coincident, w.coinc);
                if (o_saturated !== w.sat)
                    report_mismatch("saturated", o_saturated, w.sat);
            end
        end
    end

    function automatic logic [WB-1:0] rnd_word();
        return $urandom();
    endfunction

    // pair mostly near contact, b offset from a on the scale of the radii; some random, some coincident
    function automatic t_pair rnd_pair();
        t_pair p;
        int sh;
        p.ax = rnd_word(); p.ay = rnd_word(); p.az = rnd_word();
        case ($urandom_range(9))
            0: begin
                p.bx = rnd_word(); p.by = rnd_word(); p.bz = rnd_word();
                p.ra = (WB-1)'(rnd_word()); p.rb = (WB-1)'(rnd_word());
            end
            1: begin
                p.bx = p.ax; p.by = p.ay; p.bz = p.az;
                p.ra = $urandom_range(1) ? (WB-1)'(rnd_word()) : '0;
                p.rb = $urandom_range(1) ? (WB-1)'(rnd_word()) : '0;
            end
            default: begin
                sh = $urandom_range(28, 4);
                p.bx = p.ax + ($signed(rnd_word()) >>> (WB - sh));
                p.by = p.ay + ($signed(rnd_word()) >>> (WB - sh));
                p.bz = p.az + ($signed(rnd_word()) >>> (WB - sh));
                p.ra = (WB-1)'(rnd_word() >> (WB - sh));
                p.rb = (WB-1)'(rnd_word() >> (WB - sh));
            end
        endcase
        return p;
    endfunction

    task automatic test_directed();
        t_pair p;
        p = '0;
        send_pair(p);                               // coincident, zero radii
        p.ra = 1; send_pair(p);                     // coincident with radius
        p = '0; p.bx = 32'sh0001_0000; p.ra = 31'h0001_0000; send_pair(p); // touching
        p.rb = 31'h0000_8000; send_pair(p);         // overlapping on x
        p = '0; p.by = -32'sh0001_0000; p.ra = 31'h7fff_ffff; p.rb = 31'h7fff_ffff;
        send_pair(p);                               // saturates negative y
        p = '0; p.az = 32'sh7fff_ffff; p.bz = 32'sh8000_0000; send_pair(p);
        p.az = 32'sh8000_0000; p.bz = 32'sh7fff_ffff; send_pair(p);
        p = '0; p.ax = 32'sh8000_0000; p.ay = 32'sh8000_0000; p.az = 32'sh8000_0000;
        p.bx = 32'sh7fff_ffff; p.by = 32'sh7fff_ffff; p.bz = 32'sh7fff_ffff;
        p.ra = '1; p.rb = '1; send_pair(p);         // widest distance, no contact
        p = '0; p.bx = 1; p.by = -1; p.bz = 1; p.ra = 2; send_pair(p); // smallest overlap
        p = '0; p.bz = 3; p.ra = 3; send_pair(p);   // zero overlap
        p.ra = '1; p.ax = '1; send_pair(p);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_pair(rnd_pair());
    endtask

    task automatic test_backpressure();
        hold_request = hold_request + 1;
        for (int i = 0; i < 2 * LATENCY; i++) send_pair(rnd_pair());
        drain();
    endtask

    task automatic test_no_idle();
        idle_pct = 0;
        test_random(150);
        idle_pct = 25;
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(100);
        write_stiffness('0);
        test_random(60);
        write_stiffness('1);
        test_directed();
        test_random(60);
        write_stiffness(32'h0000_0001);
        test_random(60);
        write_stiffness(32'h0400_0000);
        test_backpressure();
        test_no_idle();
        write_stiffness(rnd_word());
        test_random(200);
        drain();
        if (errors == 0) begin
            $display("sphere_contact_spring_force_core: match");
        end else begin
            $display("sphere_contact_spring_force_core: mismatch");
        end
        $finish;
    end

    initial begin
        #(50_000_000);
        $display("sphere_contact_spring_force_core: mismatch");
        $finish;
    end
endmodule

FILE: sphere_contact_spring_force_core.f
+incdir+rtl
rtl/scsf_pkg.sv
rtl/sphere_contact_spring_force_core.sv
tb/sv/testbench.sv
